### sv/padded_integer_to_digits_unit_macros.svh
// Assertion macros shared by the integer-to-digits formatter.
`ifndef PADDED_INTEGER_TO_DIGITS_UNIT_MACROS_SVH
`define PADDED_INTEGER_TO_DIGITS_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PITD_CHECK_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PITD_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/pitd_pkg.sv
// Shared widths, codes and types of the integer-to-digits formatter.
package pitd_pkg;

   localparam int VALUE_W    = 33;
   localparam int FWIDTH_W   = 7;
   localparam int PREC_W     = 6;
   localparam int MODE_W     = 2;
   localparam int CHAR_W     = 8;
   localparam int MAG_W      = 32;
   localparam int DIGIT_W    = 4;
   localparam int RADIX_W    = 5;
   localparam int LEN_W      = 7;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;

   localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

   typedef enum logic [MODE_W-1:0] {
      JM_RIGHT = 2'd0,
      JM_LEFT  = 2'd1,
      JM_ZERO  = 2'd2,
      JM_NONE  = 2'd3
   } justify_type;

   typedef enum logic [1:0] {
      REG_RADIX    = 2'd0,
      REG_MAP_LOW  = 2'd1,
      REG_MAP_HIGH = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic                 done;
      logic [MAG_W-1:0]     quotient;
      logic [DIGIT_W-1:0]   remainder;
   } div_res_type;

endpackage

### sv/pitd_channels.sv
// Handshake interfaces for the request and response words of the formatter.
interface pitd_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [pitd_pkg::VALUE_W-1:0]   value;
   logic [pitd_pkg::FWIDTH_W-1:0]         field_width;
   logic                                  has_precision;
   logic [pitd_pkg::PREC_W-1:0]           precision;
   logic [pitd_pkg::MODE_W-1:0]           justify_mode;

   modport source (output valid, value, field_width, has_precision, precision, justify_mode,
                   input ready);
   modport sink (input valid, value, field_width, has_precision, precision, justify_mode,
                 output ready);
endinterface

interface pitd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pitd_pkg::CHAR_W-1:0]   out_char;
   logic                          is_last;

   modport source (output valid, out_char, is_last, input ready);
   modport sink (input valid, out_char, is_last, output ready);
endinterface

### sv/pitd_radix_div.sv
// Bit-serial restoring divider of a 32-bit magnitude by the radix.
module pitd_radix_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [pitd_pkg::MAG_W-1:0]        dividend,
   input  logic [pitd_pkg::RADIX_W-1:0]      divisor,
   output pitd_pkg::div_res_type             res
);

   localparam int MW = pitd_pkg::MAG_W;
   localparam int DW = pitd_pkg::DIGIT_W;
   localparam int CW = $clog2(MW);

   logic [MW-1:0]  q_ff, q_in;
   logic [DW-1:0]  rem_ff, rem_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic [DW:0]    trial;
   logic           fits;
   logic [DW:0]    diff;
   logic [MW-1:0]  q_step;
   logic [DW-1:0]  rem_step;

   // One quotient bit per cycle: the remainder stays below the divisor.
   always_comb begin
      trial    = {rem_ff, q_ff[MW-1]};
      fits     = (trial >= divisor);
      diff     = trial - divisor;
      rem_step = fits ? diff[DW-1:0] : trial[DW-1:0];
      q_step   = {q_ff[MW-2:0], fits};

      res.done      = busy_ff && (cnt_ff == '1);
      res.quotient  = q_step;
      res.remainder = rem_step;

      q_in    = q_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         q_in    = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         q_in   = q_step;
         rem_in = rem_step;
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
   end

endmodule

### sv/padded_integer_to_digits_unit.sv
// Top level of the printf-style integer formatter with width, precision and justification.
//
//   channel   direction   port group     contents of one word
//   request   in          req_ch         value, field_width, has_precision, precision, mode
//   response  out         rsp_ch         out_char, is_last (one character per word)
//   config    in/out      csr_*          radix and the two digit maps, APB style
//
// One conversion at a time. A request word is taken in the idle state only.
// Digits come out of a bit-serial divider, one division per digit, least
// significant first; at most MAX_DIGITS digits are split.
// Layout passes the S_BODY and S_SIZE states; characters then go out while the response
// side is ready, with a step without output at the end of every segment that is passed.
// Reset is synchronous and clears the state machine, the output valid and the
// configuration registers; a stalled response holds the character register and
// pauses output.
`include "padded_integer_to_digits_unit_macros.svh"

module padded_integer_to_digits_unit #(
   parameter int MAX_DIGITS = 32,
   parameter int MAX_FIELD  = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   pitd_req_if.sink                             req_ch,
   pitd_rsp_if.source                           rsp_ch,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [pitd_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [pitd_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [pitd_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   localparam int AW  = $clog2(MAX_DIGITS);
   localparam int NDW = $clog2(MAX_DIGITS + 1);
   localparam int LW  = pitd_pkg::LEN_W;
   localparam int MW  = pitd_pkg::MAG_W;
   localparam int DW  = pitd_pkg::DIGIT_W;
   localparam int CHW = pitd_pkg::CHAR_W;
   localparam int RW  = pitd_pkg::RADIX_W;
   localparam int XW  = pitd_pkg::CSR_DATA_W;

   // The sequencer walks the text segments in print order.
   typedef enum logic [8:0] {
      S_IDLE  = 9'b0_0000_0001,
      S_DIV   = 9'b0_0000_0010,
      S_BODY  = 9'b0_0000_0100,
      S_SIZE  = 9'b0_0000_1000,
      S_LEAD  = 9'b0_0001_0000,
      S_SIGN  = 9'b0_0010_0000,
      S_ZERO  = 9'b0_0100_0000,
      S_DIGIT = 9'b0_1000_0000,
      S_TRAIL = 9'b1_0000_0000
   } state_type;

   state_type               state_ff, state_in;

   // Configuration registers.
   logic [RW-1:0]           radix_ff, radix_in;
   logic [XW-1:0]           map_lo_ff, map_lo_in;
   logic [XW-1:0]           map_hi_ff, map_hi_in;

   // Captured request.
   logic                    neg_ff, neg_in;
   logic                    mzero_ff, mzero_in;
   logic [LW-1:0]           width_ff, width_in;
   logic                    hasp_ff, hasp_in;
   logic [pitd_pkg::PREC_W-1:0] prec_ff, prec_in;
   pitd_pkg::justify_type   mode_ff, mode_in;
   logic [RW-1:0]           rdx_ff, rdx_in;

   // Layout counters.
   logic [NDW-1:0]          nd_ff, nd_in;
   logic [LW-1:0]           cntall_ff, cntall_in;
   logic [LW-1:0]           body_ff, body_in;
   logic [LW-1:0]           lead_ff, lead_in;
   logic [LW-1:0]           zeros_ff, zeros_in;
   logic [LW-1:0]           dcnt_ff, dcnt_in;
   logic [LW-1:0]           trail_ff, trail_in;
   logic [LW-1:0]           left_ff, left_in;
   logic                    zc_ff, zc_in;
   logic                    sign_ff, sign_in;
   logic [AW-1:0]           dp_ff, dp_in;

   // Digit store and its registered read port.
   logic [DW-1:0]           digit_mem [MAX_DIGITS];
   logic [DW-1:0]           rd_data_ff;
   logic                    digit_we;

   // Response register.
   logic                    out_valid_ff, out_valid_in;
   logic [CHW-1:0]          out_char_ff, out_char_in;
   logic                    out_last_ff, out_last_in;

   // Divider hookup.
   logic                    div_start;
   logic [MW-1:0]           div_dividend;
   pitd_pkg::div_res_type   div_res;

   // Combinational helpers.
   logic                    accept;
   logic                    out_free;
   logic                    emit;
   logic [CHW-1:0]          emit_char;
   logic [MW-1:0]           raw_low;
   logic [MW-1:0]           mag_calc;
   logic [RW-1:0]           rdx_calc;
   logic [LW-1:0]           max_field;
   logic [NDW-1:0]          nd_next;
   logic [NDW-1:0]          nd_less;
   logic [LW-1:0]           nd_l;
   logic [LW-1:0]           sgn_l;
   logic [LW-1:0]           prec_l;
   logic [LW-1:0]           prec_s;
   logic [LW-1:0]           gap;
   logic [LW-1:0]           zfill;
   logic [LW-1:0]           pz;
   logic [LW-1:0]           total;
   logic                    pads_front;
   logic                    zero_case;
   logic [XW-1:0]           map_sel;
   logic [CHW-1:0]          glyph;
   logic                    csr_write;
   pitd_pkg::csr_reg_type   csr_idx;

   pitd_radix_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (rdx_ff),
      .res      (div_res)
   );

   // Configuration port: always ready, register index from the upper address bits.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = pitd_pkg::csr_reg_type'(csr_paddr[pitd_pkg::CSR_ADDR_W-1:3]);

   always_comb begin
      radix_in  = radix_ff;
      map_lo_in = map_lo_ff;
      map_hi_in = map_hi_ff;
      if (csr_write) begin
         unique case (csr_idx)
            pitd_pkg::REG_RADIX:    radix_in  = csr_pwdata[RW-1:0];
            pitd_pkg::REG_MAP_LOW:  map_lo_in = csr_pwdata;
            pitd_pkg::REG_MAP_HIGH: map_hi_in = csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         pitd_pkg::REG_RADIX:    csr_prdata = XW'(radix_ff);
         pitd_pkg::REG_MAP_LOW:  csr_prdata = map_lo_ff;
         pitd_pkg::REG_MAP_HIGH: csr_prdata = map_hi_ff;
         default:                csr_prdata = '0;
      endcase
   end

   assign req_ch.ready    = (state_ff == S_IDLE);
   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.out_char = out_char_ff;
   assign rsp_ch.is_last  = out_last_ff;

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !out_valid_ff || rsp_ch.ready;

   // The magnitude of a negative value is its two's complement; minus 2^32 saturates.
   always_comb begin
      raw_low = req_ch.value[MW-1:0];
      if (!req_ch.value[MW]) begin
         mag_calc = raw_low;
      end else if (raw_low == '0) begin
         mag_calc = '1;
      end else begin
         mag_calc = ~raw_low + MW'(1);
      end

      if (radix_ff < pitd_pkg::RADIX_MIN) begin
         rdx_calc = pitd_pkg::RADIX_MIN;
      end else if (radix_ff > pitd_pkg::RADIX_MAX) begin
         rdx_calc = pitd_pkg::RADIX_MAX;
      end else begin
         rdx_calc = radix_ff;
      end
   end

   // Digit symbol lookup: one byte out of the selected 64-bit map.
   always_comb begin
      map_sel = rd_data_ff[DW-1] ? map_hi_ff : map_lo_ff;
      glyph   = map_sel[{rd_data_ff[DW-2:0], 3'b000} +: CHW];
   end

   assign max_field = LW'(MAX_FIELD);
   assign nd_next   = nd_ff + NDW'(1);
   assign nd_less   = nd_ff - NDW'(1);
   assign nd_l      = LW'(nd_ff);
   assign sgn_l     = LW'(neg_ff);
   assign prec_l    = LW'(prec_ff);
   assign prec_s    = prec_l + sgn_l;

   // Segment lengths, used in the sizing state once the digit count is known.
   always_comb begin
      gap        = (width_ff > body_ff) ? (width_ff - body_ff) : '0;
      pads_front = (mode_ff == pitd_pkg::JM_RIGHT) || ((mode_ff == pitd_pkg::JM_ZERO) && hasp_ff);
      zfill      = ((mode_ff == pitd_pkg::JM_ZERO) && !hasp_ff && (width_ff > cntall_ff)) ?
                   (width_ff - cntall_ff) : '0;
      pz         = (hasp_ff && (prec_l > nd_l)) ? (prec_l - nd_l) : '0;
      zero_case  = hasp_ff && (prec_ff == '0) && mzero_ff;
      // The full text is as long as the body, or the field width when padding applies.
      // A zero printed with precision zero and no width yields no text at all.
      if (zero_case && (width_ff == '0)) begin
         total = '0;
      end else if (mode_ff == pitd_pkg::JM_NONE) begin
         total = body_ff;
      end else begin
         total = (width_ff > body_ff) ? width_ff : body_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      mzero_in     = mzero_ff;
      width_in     = width_ff;
      hasp_in      = hasp_ff;
      prec_in      = prec_ff;
      mode_in      = mode_ff;
      rdx_in       = rdx_ff;
      nd_in        = nd_ff;
      cntall_in    = cntall_ff;
      body_in      = body_ff;
      lead_in      = lead_ff;
      zeros_in     = zeros_ff;
      dcnt_in      = dcnt_ff;
      trail_in     = trail_ff;
      left_in      = left_ff;
      zc_in        = zc_ff;
      sign_in      = sign_ff;
      dp_in        = dp_ff;
      digit_we     = 1'b0;
      div_start    = 1'b0;
      div_dividend = mag_calc;
      emit         = 1'b0;
      emit_char    = pitd_pkg::CH_SPACE;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               neg_in    = req_ch.value[MW];
               mzero_in  = (req_ch.value == '0);
               width_in  = (req_ch.field_width > max_field) ? max_field : req_ch.field_width;
               hasp_in   = req_ch.has_precision;
               prec_in   = req_ch.precision;
               mode_in   = pitd_pkg::justify_type'(req_ch.justify_mode);
               rdx_in    = rdx_calc;
               nd_in     = '0;
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end

         // Each finished division leaves one digit, least significant first.
         S_DIV: begin
            if (div_res.done) begin
               digit_we = 1'b1;
               nd_in    = nd_next;
               if ((div_res.quotient == '0) || (nd_next == NDW'(MAX_DIGITS))) begin
                  state_in = S_BODY;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = div_res.quotient;
               end
            end
         end

         S_BODY: begin
            cntall_in = nd_l + sgn_l;
            body_in   = (hasp_ff && (prec_s > nd_l + sgn_l)) ? prec_s : (nd_l + sgn_l);
            state_in  = S_SIZE;
         end

         S_SIZE: begin
            lead_in  = pads_front ? gap : '0;
            trail_in = (mode_ff == pitd_pkg::JM_LEFT) ? gap : '0;
            zeros_in = zfill + pz;
            zc_in    = zero_case;
            dcnt_in  = zero_case ? LW'(width_ff != '0) : nd_l;
            sign_in  = neg_ff;
            left_in  = (total > max_field) ? max_field : total;
            dp_in    = nd_less[AW-1:0];
            state_in = (total == '0) ? S_IDLE : S_LEAD;
         end

         S_LEAD: begin
            if (lead_ff == '0) begin
               state_in = S_SIGN;
            end else if (out_free) begin
               emit      = 1'b1;
               emit_char = pitd_pkg::CH_SPACE;
               lead_in   = lead_ff - LW'(1);
            end
         end

         S_SIGN: begin
            if (!sign_ff) begin
               state_in = S_ZERO;
            end else if (out_free) begin
               emit      = 1'b1;
               emit_char = pitd_pkg::CH_MINUS;
               sign_in   = 1'b0;
            end
         end

         S_ZERO: begin
            if (zeros_ff == '0) begin
               state_in = S_DIGIT;
            end else if (out_free) begin
               emit      = 1'b1;
               emit_char = pitd_pkg::CH_ZERO;
               zeros_in  = zeros_ff - LW'(1);
            end
         end

         // Digits leave the store most significant first; a lone zero with
         // precision zero turns into a space.
         S_DIGIT: begin
            if (dcnt_ff == '0) begin
               state_in = S_TRAIL;
            end else if (out_free) begin
               emit      = 1'b1;
               emit_char = zc_ff ? pitd_pkg::CH_SPACE : glyph;
               dcnt_in   = dcnt_ff - LW'(1);
               dp_in     = dp_ff - AW'(1);
            end
         end

         S_TRAIL: begin
            if (trail_ff == '0) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               emit      = 1'b1;
               emit_char = pitd_pkg::CH_SPACE;
               trail_in  = trail_ff - LW'(1);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // The overall character budget ends the conversion, which also cuts
      // over-long text at the field limit.
      if (emit) begin
         left_in = left_ff - LW'(1);
         if (left_ff == LW'(1)) begin
            state_in = S_IDLE;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_char_in  = emit_char;
         out_last_in  = (left_ff == LW'(1));
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         radix_ff     <= pitd_pkg::RADIX_RESET;
         map_lo_ff    <= '0;
         map_hi_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         radix_ff     <= radix_in;
         map_lo_ff    <= map_lo_in;
         map_hi_ff    <= map_hi_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      mzero_ff    <= mzero_in;
      width_ff    <= width_in;
      hasp_ff     <= hasp_in;
      prec_ff     <= prec_in;
      mode_ff     <= mode_in;
      rdx_ff      <= rdx_in;
      nd_ff       <= nd_in;
      cntall_ff   <= cntall_in;
      body_ff     <= body_in;
      lead_ff     <= lead_in;
      zeros_ff    <= zeros_in;
      dcnt_ff     <= dcnt_in;
      trail_ff    <= trail_in;
      left_ff     <= left_in;
      zc_ff       <= zc_in;
      sign_ff     <= sign_in;
      dp_ff       <= dp_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   // The read address follows the next pointer, so the registered data
   // always matches the current pointer.
   always_ff @(posedge clock) begin
      if (digit_we) begin
         digit_mem[nd_ff[AW-1:0]] <= div_res.remainder;
      end
      rd_data_ff <= digit_mem[dp_in];
   end

   `PITD_CHECK_NOW(a_emit_budget, clock, reset, emit, left_ff != '0, "character emitted past the text length")
   `PITD_CHECK_NOW(a_digit_ptr, clock, reset, (state_ff == S_DIGIT) && !zc_ff && (dcnt_ff != '0), (LW'(dp_ff) + LW'(1)) == dcnt_ff, "digit pointer out of step with the digit count")
   `PITD_CHECK_NEXT(a_last_idle, clock, reset, emit && out_last_in, state_ff == S_IDLE, "conversion continued after its last character")
   `PITD_CHECK_NOW(a_div_owner, clock, reset, div_res.done, state_ff == S_DIV, "division finished outside the digit split")

endmodule
